[rtl/core/assert_macros.svh]
// Assertion macros used by the filter's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

[rtl/core/c3x3ef_pkg.sv]
// Types and constants of the 3x3 extremum filter.
package c3x3ef_pkg;

   localparam int MaxDim   = 1024;
   localparam int DimW     = 11;
   localparam int PosW     = $clog2(MaxDim);
   localparam int PixW     = 24;
   localparam int SumW     = 21;
   localparam int DivW     = 20;
   localparam int DivSteps = DivW;
   localparam int DivCntW  = $clog2(DivSteps);
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 24;

   localparam logic [9:0]  IntensityInit = 10'd766;
   localparam logic [7:0]  ChanMax       = 8'd255;
   localparam logic signed [10:0] IntensityNone = -11'sd1;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_IMAGE_DIM     = 3'd0,
      CSR_KERNEL_TOP    = 3'd1,
      CSR_KERNEL_MIDDLE = 3'd2,
      CSR_KERNEL_BOTTOM = 3'd3,
      CSR_KERNEL_SCALE  = 3'd4,
      CSR_EXTREMUM      = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic       accept;
      logic       read;
      logic       shift;
      logic       clear;
      logic       acc;
      logic       extr;
      logic       div_step;
      logic       oi;
      logic       oj;
      logic [1:0] kr;
      logic [1:0] kc;
   } cmd_type;

   typedef struct packed {
      logic row_up;
      logic row_same;
      logic col_left;
      logic col_same;
   } sts_type;

endpackage

[rtl/core/c3x3ef_ctrl.sv]
// Controller state machine of the 3x3 extremum filter.
module c3x3ef_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_last_of_run,
   output c3x3ef_pkg::cmd_type  cmd,
   input  c3x3ef_pkg::sts_type  sts
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_SHIFT, ST_PICK, ST_ACC, ST_EXTR, ST_DIV, ST_SEND
   } state_type;

   state_type                         state_ff, state_in;
   logic [1:0]                        q_ff, q_in;
   logic [1:0]                        kr_ff, kr_in;
   logic [1:0]                        kc_ff, kc_in;
   logic [c3x3ef_pkg::DivCntW-1:0]    cnt_ff, cnt_in;
   logic [3:0]                        out_ok;
   logic                              last;

   always_comb begin
      out_ok[0] = sts.row_up   & sts.col_left;
      out_ok[1] = sts.row_up   & sts.col_same;
      out_ok[2] = sts.row_same & sts.col_left;
      out_ok[3] = sts.row_same & sts.col_same;
      case (q_ff)
         2'd0:    last = ~(out_ok[1] | out_ok[2] | out_ok[3]);
         2'd1:    last = ~(out_ok[2] | out_ok[3]);
         2'd2:    last = ~out_ok[3];
         default: last = 1'b1;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      q_in     = q_ff;
      kr_in    = kr_ff;
      kc_in    = kc_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            q_in = 2'd0;
            if (req_valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            state_in = ST_PICK;
         end
         ST_PICK: begin
            kr_in = 2'd0;
            kc_in = 2'd0;
            if (out_ok[q_ff]) begin
               state_in = ST_ACC;
            end else if (q_ff == 2'd3) begin
               state_in = ST_IDLE;
            end else begin
               q_in = q_ff + 2'd1;
            end
         end
         ST_ACC: begin
            if (kc_ff == 2'd2) begin
               kc_in = 2'd0;
               kr_in = kr_ff + 2'd1;
               if (kr_ff == 2'd2) begin
                  state_in = ST_EXTR;
               end
            end else begin
               kc_in = kc_ff + 2'd1;
            end
         end
         ST_EXTR: begin
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == c3x3ef_pkg::DivCntW'(c3x3ef_pkg::DivSteps - 1)) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (!rsp_stall) begin
               if (last) begin
                  state_in = ST_IDLE;
               end else begin
                  q_in     = q_ff + 2'd1;
                  state_in = ST_PICK;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         q_ff     <= 2'd0;
         kr_ff    <= 2'd0;
         kc_ff    <= 2'd0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         q_ff     <= q_in;
         kr_ff    <= kr_in;
         kc_ff    <= kc_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_SEND);
   assign rsp_last_of_run = last;

   always_comb begin
      cmd.accept   = (state_ff == ST_IDLE) & req_valid;
      cmd.read     = (state_ff == ST_READ);
      cmd.shift    = (state_ff == ST_SHIFT);
      cmd.clear    = (state_ff == ST_PICK);
      cmd.acc      = (state_ff == ST_ACC);
      cmd.extr     = (state_ff == ST_EXTR);
      cmd.div_step = (state_ff == ST_DIV);
      cmd.oi       = q_ff[1];
      cmd.oj       = q_ff[0];
      cmd.kr       = kr_ff;
      cmd.kc       = kc_ff;
   end

endmodule

[rtl/core/c3x3ef_datapath.sv]
// Datapath of the 3x3 extremum filter: registers, line stores, window, MAC, divider.
module c3x3ef_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [c3x3ef_pkg::CsrIdxW-1:0]      csr_index,
   input  logic [c3x3ef_pkg::CsrDataW-1:0]     csr_wdata,
   input  logic [7:0]                          req_red_in,
   input  logic [7:0]                          req_green_in,
   input  logic [7:0]                          req_blue_in,
   input  c3x3ef_pkg::cmd_type                 cmd,
   output c3x3ef_pkg::sts_type                 sts,
   output logic [7:0]                          rsp_red_out,
   output logic [7:0]                          rsp_green_out,
   output logic [7:0]                          rsp_blue_out,
   output logic [c3x3ef_pkg::PosW-1:0]         rsp_out_row,
   output logic [c3x3ef_pkg::PosW-1:0]         rsp_out_col
);

   localparam int PosW = c3x3ef_pkg::PosW;
   localparam int DimW = c3x3ef_pkg::DimW;
   localparam int PixW = c3x3ef_pkg::PixW;
   localparam int SumW = c3x3ef_pkg::SumW;
   localparam int DivW = c3x3ef_pkg::DivW;

   logic [DimW-1:0]   dim_ff;
   logic [23:0]       ktop_ff, kmid_ff, kbot_ff;
   logic [7:0]        scale_ff;
   logic              extr_ff;
   logic [PosW-1:0]   cnt_row_ff, cnt_row_in;
   logic [PosW-1:0]   cnt_col_ff, cnt_col_in;

   logic [PosW-1:0]   r_ff, c_ff;
   logic [PixW-1:0]   pix_ff;
   logic [PixW-1:0]   older_rd_ff, newer_rd_ff;
   logic [PixW-1:0]   older_mem [c3x3ef_pkg::MaxDim];
   logic [PixW-1:0]   newer_mem [c3x3ef_pkg::MaxDim];
   logic [PixW-1:0]   win_ff [3][3];

   logic signed [SumW-1:0] sum_ff [3];
   logic signed [SumW-1:0] sum_in [3];
   logic [9:0]             min_v_ff, min_v_in;
   logic signed [10:0]     max_v_ff, max_v_in;
   logic [PixW-1:0]        min_p_ff, min_p_in, max_p_ff, max_p_in;

   logic [DivW-1:0]   div_ff [3];
   logic [DivW-1:0]   div_in [3];
   logic [7:0]        rem_ff [3];
   logic [7:0]        rem_in [3];
   logic [2:0]        neg_ff, neg_in;

   logic [DimW-1:0]   dim_eff;
   logic [PosW-1:0]   dim_m1;
   logic [7:0]        scale_eff;
   logic              wrap;
   logic [PosW-1:0]   i_pos, j_pos;
   logic [2:0]        a_sum, b_sum;
   logic              nb_ok;
   logic [PixW-1:0]   nb_pix;
   logic [23:0]       krow;
   logic signed [7:0] coef;
   logic signed [16:0] prod [3];
   logic [9:0]        nb_v;
   logic [9:0]        ext_sum [3];
   logic signed [SumW-1:0] net [3];
   logic [8:0]        trial [3];
   logic [7:0]        res [3];

   always_comb begin
      if (dim_ff == '0) begin
         dim_eff = DimW'(1);
      end else if (dim_ff > DimW'(c3x3ef_pkg::MaxDim)) begin
         dim_eff = DimW'(c3x3ef_pkg::MaxDim);
      end else begin
         dim_eff = dim_ff;
      end
      dim_m1    = PosW'(dim_eff - DimW'(1));
      scale_eff = (scale_ff == 8'd0) ? 8'd1 : scale_ff;
      wrap      = ({1'b0, cnt_row_ff} >= dim_eff) || ({1'b0, cnt_col_ff} >= dim_eff);
   end

   always_comb begin
      cnt_row_in = cnt_row_ff;
      cnt_col_in = cnt_col_ff;
      if (cmd.shift) begin
         if (c_ff == dim_m1) begin
            cnt_col_in = '0;
            cnt_row_in = (r_ff == dim_m1) ? '0 : r_ff + 1'b1;
         end else begin
            cnt_col_in = c_ff + 1'b1;
            cnt_row_in = r_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff     <= DimW'(512);
         ktop_ff    <= 24'h010101;
         kmid_ff    <= 24'h010101;
         kbot_ff    <= 24'h010101;
         scale_ff   <= 8'd9;
         extr_ff    <= 1'b0;
         cnt_row_ff <= '0;
         cnt_col_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            c3x3ef_pkg::CSR_IMAGE_DIM: begin
               dim_ff     <= csr_wdata[DimW-1:0];
               cnt_row_ff <= '0;
               cnt_col_ff <= '0;
            end
            c3x3ef_pkg::CSR_KERNEL_TOP:    ktop_ff  <= csr_wdata;
            c3x3ef_pkg::CSR_KERNEL_MIDDLE: kmid_ff  <= csr_wdata;
            c3x3ef_pkg::CSR_KERNEL_BOTTOM: kbot_ff  <= csr_wdata;
            c3x3ef_pkg::CSR_KERNEL_SCALE:  scale_ff <= csr_wdata[7:0];
            c3x3ef_pkg::CSR_EXTREMUM:      extr_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end else begin
         cnt_row_ff <= cnt_row_in;
         cnt_col_ff <= cnt_col_in;
      end
   end

   // line stores
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         older_rd_ff <= older_mem[c_ff];
         newer_rd_ff <= newer_mem[c_ff];
      end
      if (cmd.shift) begin
         older_mem[c_ff] <= newer_rd_ff;
         newer_mem[c_ff] <= pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff <= {req_blue_in, req_green_in, req_red_in};
         r_ff   <= wrap ? '0 : cnt_row_ff;
         c_ff   <= wrap ? '0 : cnt_col_ff;
      end
      if (cmd.shift) begin
         for (int a = 0; a < 3; a++) begin
            win_ff[a][0] <= win_ff[a][1];
            win_ff[a][1] <= win_ff[a][2];
         end
         win_ff[0][2] <= older_rd_ff;
         win_ff[1][2] <= newer_rd_ff;
         win_ff[2][2] <= pix_ff;
      end
   end

   always_comb begin
      sts.row_up   = (r_ff != '0);
      sts.row_same = (r_ff == dim_m1);
      sts.col_left = (c_ff != '0);
      sts.col_same = (c_ff == dim_m1);
      i_pos = cmd.oi ? r_ff : r_ff - 1'b1;
      j_pos = cmd.oj ? c_ff : c_ff - 1'b1;
   end

   // neighbour select, multiply-accumulate and min/max intensity tracking
   always_comb begin
      a_sum = 3'(cmd.oi) + 3'(cmd.kr);
      b_sum = 3'(cmd.oj) + 3'(cmd.kc);
      nb_ok = (a_sum <= 3'd2) && (b_sum <= 3'd2)
              && !(cmd.kr == 2'd0 && i_pos == '0) && !(cmd.kr == 2'd2 && i_pos == dim_m1)
              && !(cmd.kc == 2'd0 && j_pos == '0) && !(cmd.kc == 2'd2 && j_pos == dim_m1);
      nb_pix = win_ff[a_sum[1:0]][b_sum[1:0]];
      case (cmd.kr)
         2'd0:    krow = ktop_ff;
         2'd1:    krow = kmid_ff;
         default: krow = kbot_ff;
      endcase
      case (cmd.kc)
         2'd0:    coef = $signed(krow[7:0]);
         2'd1:    coef = $signed(krow[15:8]);
         default: coef = $signed(krow[23:16]);
      endcase
      nb_v = 10'(nb_pix[7:0]) + 10'(nb_pix[15:8]) + 10'(nb_pix[23:16]);
      for (int ch = 0; ch < 3; ch++) begin
         prod[ch]   = $signed({1'b0, nb_pix[8*ch +: 8]}) * coef;
         sum_in[ch] = sum_ff[ch];
      end
      min_v_in = min_v_ff;
      min_p_in = min_p_ff;
      max_v_in = max_v_ff;
      max_p_in = max_p_ff;
      if (cmd.clear) begin
         for (int ch = 0; ch < 3; ch++) begin
            sum_in[ch] = '0;
         end
         min_v_in = c3x3ef_pkg::IntensityInit;
         max_v_in = c3x3ef_pkg::IntensityNone;
      end else if (cmd.acc && nb_ok) begin
         for (int ch = 0; ch < 3; ch++) begin
            sum_in[ch] = sum_ff[ch] + SumW'(prod[ch]);
         end
         if (nb_v <= min_v_ff) begin
            min_v_in = nb_v;
            min_p_in = nb_pix;
         end
         if ($signed({1'b0, nb_v}) > max_v_ff) begin
            max_v_in = $signed({1'b0, nb_v});
            max_p_in = nb_pix;
         end
      end
   end

   // extremum removal, restoring divide and output clamp
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         ext_sum[ch] = 10'(min_p_ff[8*ch +: 8]) + 10'(max_p_ff[8*ch +: 8]);
         net[ch]     = extr_ff ? sum_ff[ch] - $signed({{(SumW-10){1'b0}}, ext_sum[ch]})
                               : sum_ff[ch];
         trial[ch]   = {rem_ff[ch], div_ff[ch][DivW-1]};
         div_in[ch]  = div_ff[ch];
         rem_in[ch]  = rem_ff[ch];
         neg_in[ch]  = neg_ff[ch];
         if (cmd.extr) begin
            neg_in[ch] = net[ch][SumW-1];
            div_in[ch] = net[ch][DivW-1:0];
            rem_in[ch] = '0;
         end else if (cmd.div_step) begin
            if (trial[ch] >= {1'b0, scale_eff}) begin
               rem_in[ch] = 8'(trial[ch] - {1'b0, scale_eff});
               div_in[ch] = {div_ff[ch][DivW-2:0], 1'b1};
            end else begin
               rem_in[ch] = trial[ch][7:0];
               div_in[ch] = {div_ff[ch][DivW-2:0], 1'b0};
            end
         end
         if (neg_ff[ch]) begin
            res[ch] = 8'd0;
         end else if (|div_ff[ch][DivW-1:8]) begin
            res[ch] = c3x3ef_pkg::ChanMax;
         end else begin
            res[ch] = div_ff[ch][7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < 3; ch++) begin
         sum_ff[ch] <= sum_in[ch];
         div_ff[ch] <= div_in[ch];
         rem_ff[ch] <= rem_in[ch];
      end
      neg_ff   <= neg_in;
      min_v_ff <= min_v_in;
      min_p_ff <= min_p_in;
      max_v_ff <= max_v_in;
      max_p_ff <= max_p_in;
   end

   assign rsp_red_out   = res[0];
   assign rsp_green_out = res[1];
   assign rsp_blue_out  = res[2];
   assign rsp_out_row   = i_pos;
   assign rsp_out_col   = j_pos;

endmodule

[rtl/core/conv3x3_extremum_filter.sv]
// A request can yield several results; a new request is taken only after the previous one
// has sent all of them, so result stalls hold new requests off. Each result walks the
// 9 neighbours through one shared multiply-accumulate and then a 20-step one-bit divider.
// Reset (synchronous, active high): registers to defaults, position to row 0, col 0.
// Line stores and window hold no reset; entries read before being written feed only neighbours outside the image.
`include "assert_macros.svh"

module conv3x3_extremum_filter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [c3x3ef_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [c3x3ef_pkg::CsrDataW-1:0]   csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_red_in,
   input  logic [7:0]                        req_green_in,
   input  logic [7:0]                        req_blue_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_red_out,
   output logic [7:0]                        rsp_green_out,
   output logic [7:0]                        rsp_blue_out,
   output logic [c3x3ef_pkg::PosW-1:0]       rsp_out_row,
   output logic [c3x3ef_pkg::PosW-1:0]       rsp_out_col,
   output logic                              rsp_last_of_run
);

   c3x3ef_pkg::cmd_type cmd;
   c3x3ef_pkg::sts_type sts;

   c3x3ef_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_last_of_run (rsp_last_of_run),
      .cmd             (cmd),
      .sts             (sts)
   );

   c3x3ef_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col)
   );

   `ASSERT_IMPLY(a_rsp_blocks_req, clock, reset, rsp_valid, req_stall)
   `ASSERT_NEXT(a_req_no_early_rsp, clock, reset, req_valid && !req_stall, !rsp_valid)
   `ASSERT_NEXT(a_last_frees_req, clock, reset, rsp_valid && !rsp_stall && rsp_last_of_run, !req_stall)

endmodule
